// ===== src/sca_pkg.sv =====
// shared types, codes and sizes for the sparse column scatter-accumulate core
// no dependencies; used by every module of the core
package sca_pkg;

   // table sizes
   localparam int MAX_COLS    = 1024;
   localparam int MAX_NNZ     = 16384;
   localparam int COL_IW      = $clog2(MAX_COLS);
   localparam int COL_AW      = $clog2(MAX_COLS + 1);
   localparam int SLOT_AW     = $clog2(MAX_NNZ);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // operation codes
   localparam logic [1:0] OP_LOAD_COL = 2'd0;
   localparam logic [1:0] OP_LOAD_ROW = 2'd1;
   localparam logic [1:0] OP_ACCUM    = 2'd2;
   localparam logic [1:0] OP_READ     = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_MISS  = 2'd2;
   localparam logic [1:0] ST_SAT   = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_NUM_COLS   = 2'd0;
   localparam logic [1:0] CSR_ROW_OFFSET = 2'd1;
   localparam logic [1:0] CSR_COL_OFFSET = 2'd2;

   // classified request passed from front to back
   typedef struct packed {
      logic [1:0]         operation;
      logic [14:0]        slot_address;
      logic [14:0]        load_word;
      logic signed [16:0] row;
      logic [COL_IW-1:0]  col;
      logic               col_ok;
      logic signed [63:0] contribution;
      logic               end_of_element;
   } item_type;

endpackage

// ===== src/sca_front.sv =====
// front end: configuration registers, request intake and classification
// depends on sca_pkg
module sca_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_operation,
   input  logic [14:0]         req_slot_address,
   input  logic [14:0]         req_load_word,
   input  logic signed [15:0]  req_row_index,
   input  logic signed [15:0]  req_column_index,
   input  logic signed [63:0]  req_contribution,
   input  logic                req_end_of_element,
   input  logic                clearing,
   input  logic                q_full,
   output logic                q_wr,
   output sca_pkg::item_type   q_wdata
);

   logic [10:0]        num_cols_ff, num_cols_in;
   logic signed [15:0] row_offset_ff, row_offset_in;
   logic signed [15:0] col_offset_ff, col_offset_in;
   logic               csr_wr;
   logic [1:0]         csr_idx;
   logic signed [16:0] col_sum;
   logic signed [16:0] col_limit;

   // register writes
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      num_cols_in   = num_cols_ff;
      row_offset_in = row_offset_ff;
      col_offset_in = col_offset_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            sca_pkg::CSR_NUM_COLS:   num_cols_in   = csr_pwdata[10:0];
            sca_pkg::CSR_ROW_OFFSET: row_offset_in = csr_pwdata[15:0];
            sca_pkg::CSR_COL_OFFSET: col_offset_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff   <= 11'(sca_pkg::MAX_COLS);
         row_offset_ff <= '0;
         col_offset_ff <= '0;
      end else begin
         num_cols_ff   <= num_cols_in;
         row_offset_ff <= row_offset_in;
         col_offset_ff <= col_offset_in;
      end
   end

   // register reads
   always_comb begin
      unique case (csr_idx)
         sca_pkg::CSR_NUM_COLS:   csr_prdata = {21'd0, num_cols_ff};
         sca_pkg::CSR_ROW_OFFSET: csr_prdata = {16'd0, row_offset_ff};
         sca_pkg::CSR_COL_OFFSET: csr_prdata = {16'd0, col_offset_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   // intake: hold off while the queue is full or the sums are being cleared
   assign req_ready = ~q_full & ~clearing;
   assign q_wr      = req_valid & req_ready;

   // offset the column and check it against the columns in use
   assign col_sum   = 17'(req_column_index) + 17'(col_offset_ff);
   assign col_limit = (num_cols_ff > 11'(sca_pkg::MAX_COLS)) ?
                      17'(sca_pkg::MAX_COLS) : $signed({6'd0, num_cols_ff});

   always_comb begin
      q_wdata.operation      = req_operation;
      q_wdata.slot_address   = req_slot_address;
      q_wdata.load_word      = req_load_word;
      q_wdata.row            = 17'(req_row_index) + 17'(row_offset_ff);
      q_wdata.col            = col_sum[sca_pkg::COL_IW-1:0];
      q_wdata.col_ok         = (col_sum >= 17'sd0) && (col_sum < col_limit);
      q_wdata.contribution   = req_contribution;
      q_wdata.end_of_element = req_end_of_element;
   end

endmodule

// ===== src/sca_queue.sv =====
// short request queue between the front end and the back end
// depends on sca_pkg
module sca_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr,
   input  sca_pkg::item_type wdata,
   output logic              full,
   input  logic              rd,
   output sca_pkg::item_type rdata,
   output logic              empty
);

   sca_pkg::item_type           slots_ff [sca_pkg::QUEUE_DEPTH];
   logic [sca_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [sca_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [sca_pkg::QPTR_W:0]    count_ff, count_in;

   assign full  = (count_ff == (sca_pkg::QPTR_W+1)'(sca_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = slots_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr) begin
         wr_ptr_in = (wr_ptr_ff == sca_pkg::QPTR_W'(sca_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (rd) begin
         rd_ptr_in = (rd_ptr_ff == sca_pkg::QPTR_W'(sca_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (wr && !rd) begin
         count_in = count_ff + 1'b1;
      end else if (rd && !wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (wr) begin
         slots_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== src/sca_back.sv =====
// back end: pattern tables, slot sums, row search sequencer and result register
// depends on sca_pkg
module sca_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_empty,
   input  sca_pkg::item_type                   q_rdata,
   output logic                                q_rd,
   output logic                                clearing,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [13:0]                         rsp_found_slot,
   output logic signed [63:0]                  rsp_slot_value,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_element_done
);

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DISP  = 4'd2;
   localparam logic [3:0] S_COLS  = 4'd3;
   localparam logic [3:0] S_QUART = 4'd4;
   localparam logic [3:0] S_CMP   = 4'd5;
   localparam logic [3:0] S_BIS   = 4'd6;
   localparam logic [3:0] S_ACC   = 4'd7;
   localparam logic [3:0] S_RDV   = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   localparam logic [1:0] M_Q2  = 2'd0;
   localparam logic [1:0] M_Q3  = 2'd1;
   localparam logic [1:0] M_Q1  = 2'd2;
   localparam logic [1:0] M_BIS = 2'd3;

   localparam int SW = sca_pkg::SLOT_AW;

   // memories
   logic [14:0] cs_mem  [sca_pkg::MAX_COLS + 1];
   logic [14:0] row_mem [sca_pkg::MAX_NNZ];
   logic [63:0] sum_mem [sca_pkg::MAX_NNZ];

   logic [3:0]          state_ff, state_in;
   logic [SW-1:0]       clr_cnt_ff, clr_cnt_in;
   sca_pkg::item_type   item_ff, item_in;
   logic [SW-1:0]       lo_ff, lo_in, hi_ff, hi_in;
   logic [SW-1:0]       q1_ff, q1_in, q2_ff, q2_in, q3_ff, q3_in;
   logic signed [15:0]  a_ff, a_in, b_ff, b_in;
   logic [SW-1:0]       probe_ff, probe_in;
   logic [1:0]          mode_ff, mode_in;
   logic                res_found_ff, res_found_in;
   logic [13:0]         res_slot_ff, res_slot_in;
   logic [63:0]         res_value_ff, res_value_in;
   logic [1:0]          res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [13:0]         rsp_slot_ff, rsp_slot_in;
   logic [63:0]         rsp_value_ff, rsp_value_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic                rsp_done_ff, rsp_done_in;

   logic [14:0]         cs_rd0_ff, cs_rd1_ff;
   logic [14:0]         row_rd_ff;
   logic [63:0]         sum_rd_ff;
   logic [sca_pkg::COL_AW-1:0] cs_ra0, cs_ra1;
   logic                cs_we, row_we, sum_we;
   logic [SW-1:0]       sum_wa, sum_ra;
   logic [63:0]         sum_wd;

   logic [14:0]         cs_end;
   logic [SW-1:0]       quarter, q1c, q2c, q3c;
   logic signed [16:0]  rv;
   logic                lt, eq;
   logic signed [15:0]  mid;
   logic [63:0]         add_r;
   logic                ovf;

   // column pointer pair of the current column
   assign cs_ra0 = {1'b0, item_ff.col};
   assign cs_ra1 = cs_ra0 + 1'b1;

   always_ff @(posedge clock) begin
      if (cs_we) begin
         cs_mem[item_ff.slot_address[sca_pkg::COL_AW-1:0]] <= item_ff.load_word;
      end
      cs_rd0_ff <= cs_mem[cs_ra0];
      cs_rd1_ff <= cs_mem[cs_ra1];
   end

   // row index table, read at the next probe
   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[item_ff.slot_address[SW-1:0]] <= item_ff.load_word;
      end
      row_rd_ff <= row_mem[probe_in];
   end

   // slot sums
   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_wa] <= sum_wd;
      end
      sum_rd_ff <= sum_mem[sum_ra];
   end

   // datapath helpers
   assign cs_end  = (cs_rd1_ff > 15'(sca_pkg::MAX_NNZ)) ? 15'(sca_pkg::MAX_NNZ) : cs_rd1_ff;
   assign quarter = (hi_ff - lo_ff) >> 2;
   assign q1c     = lo_ff + quarter;
   assign q2c     = q1c + quarter;
   assign q3c     = q2c + quarter;
   assign rv      = $signed({2'b00, row_rd_ff});
   assign lt      = rv < item_ff.row;
   assign eq      = rv == item_ff.row;
   assign mid     = a_ff + ((b_ff - a_ff) >>> 1);
   assign add_r   = sum_rd_ff + item_ff.contribution;
   assign ovf     = (sum_rd_ff[63] == item_ff.contribution[63]) && (add_r[63] != sum_rd_ff[63]);

   assign clearing = (state_ff == S_CLR);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      item_in       = item_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      q1_in         = q1_ff;
      q2_in         = q2_ff;
      q3_in         = q3_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      probe_in      = probe_ff;
      mode_in       = mode_ff;
      res_found_in  = res_found_ff;
      res_slot_in   = res_slot_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_found_in  = rsp_found_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_done_in   = rsp_done_ff;
      q_rd          = 1'b0;
      cs_we         = 1'b0;
      row_we        = 1'b0;
      sum_we        = 1'b0;
      sum_wa        = item_ff.slot_address[SW-1:0];
      sum_wd        = '0;
      sum_ra        = item_ff.slot_address[SW-1:0];

      unique case (state_ff)
         // zero every slot sum after reset
         S_CLR: begin
            sum_we     = 1'b1;
            sum_wa     = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == SW'(sca_pkg::MAX_NNZ - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!q_empty) begin
               q_rd     = 1'b1;
               item_in  = q_rdata;
               state_in = S_DISP;
            end
         end
         // dispatch on the operation
         S_DISP: begin
            res_found_in  = 1'b0;
            res_slot_in   = '0;
            res_value_in  = '0;
            res_status_in = sca_pkg::ST_OK;
            state_in      = S_OUT;
            unique case (item_ff.operation)
               sca_pkg::OP_LOAD_COL: begin
                  if (item_ff.slot_address <= 15'(sca_pkg::MAX_COLS)) begin
                     cs_we        = 1'b1;
                     res_found_in = 1'b1;
                     res_slot_in  = item_ff.slot_address[13:0];
                  end else begin
                     res_status_in = sca_pkg::ST_RANGE;
                  end
               end
               sca_pkg::OP_LOAD_ROW: begin
                  if (item_ff.slot_address < 15'(sca_pkg::MAX_NNZ)) begin
                     row_we       = 1'b1;
                     sum_we       = 1'b1;
                     res_found_in = 1'b1;
                     res_slot_in  = item_ff.slot_address[13:0];
                  end else begin
                     res_status_in = sca_pkg::ST_RANGE;
                  end
               end
               sca_pkg::OP_READ: begin
                  if (item_ff.slot_address < 15'(sca_pkg::MAX_NNZ)) begin
                     state_in = S_RDV;
                  end else begin
                     res_status_in = sca_pkg::ST_RANGE;
                  end
               end
               sca_pkg::OP_ACCUM: begin
                  if (item_ff.col_ok) begin
                     state_in = S_COLS;
                  end else begin
                     res_status_in = sca_pkg::ST_RANGE;
                  end
               end
               default: ;
            endcase
         end
         S_RDV: begin
            res_found_in = 1'b1;
            res_slot_in  = item_ff.slot_address[13:0];
            res_value_in = sum_rd_ff;
            state_in     = S_OUT;
         end
         // column bounds; an empty column misses
         S_COLS: begin
            if (cs_rd0_ff < cs_end) begin
               lo_in    = cs_rd0_ff[SW-1:0];
               hi_in    = SW'(cs_end - 15'd1);
               state_in = S_QUART;
            end else begin
               res_status_in = sca_pkg::ST_MISS;
               state_in      = S_OUT;
            end
         end
         // quartile points, probe the middle one first
         S_QUART: begin
            q1_in    = q1c;
            q2_in    = q2c;
            q3_in    = q3c;
            probe_in = q2c;
            mode_in  = M_Q2;
            state_in = S_CMP;
         end
         // compare the probed row
         S_CMP: begin
            if (eq) begin
               sum_ra   = probe_ff;
               state_in = S_ACC;
            end else begin
               state_in = S_BIS;
               unique case (mode_ff)
                  M_Q2: begin
                     state_in = S_CMP;
                     if (lt) begin
                        probe_in = q3_ff;
                        mode_in  = M_Q3;
                     end else begin
                        probe_in = q1_ff;
                        mode_in  = M_Q1;
                     end
                  end
                  M_Q3: begin
                     if (lt) begin
                        a_in = $signed({2'b00, q3_ff}) + 16'sd1;
                        b_in = $signed({2'b00, hi_ff});
                     end else begin
                        a_in = $signed({2'b00, q2_ff}) + 16'sd1;
                        b_in = $signed({2'b00, q3_ff}) - 16'sd1;
                     end
                  end
                  M_Q1: begin
                     if (lt) begin
                        a_in = $signed({2'b00, q1_ff}) + 16'sd1;
                        b_in = $signed({2'b00, q2_ff}) - 16'sd1;
                     end else begin
                        a_in = $signed({2'b00, lo_ff});
                        b_in = $signed({2'b00, q1_ff}) - 16'sd1;
                     end
                  end
                  M_BIS: begin
                     if (lt) begin
                        a_in = $signed({2'b00, probe_ff}) + 16'sd1;
                     end else begin
                        b_in = $signed({2'b00, probe_ff}) - 16'sd1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // next bisection probe or miss
         S_BIS: begin
            if (a_ff <= b_ff) begin
               probe_in = mid[SW-1:0];
               mode_in  = M_BIS;
               state_in = S_CMP;
            end else begin
               res_status_in = sca_pkg::ST_MISS;
               state_in      = S_OUT;
            end
         end
         // saturating add into the slot
         S_ACC: begin
            sum_we        = 1'b1;
            sum_wa        = probe_ff;
            sum_wd        = ovf ? (sum_rd_ff[63] ? 64'h8000_0000_0000_0000 :
                                   64'h7FFF_FFFF_FFFF_FFFF) : add_r;
            res_found_in  = 1'b1;
            res_slot_in   = 14'(probe_ff);
            res_value_in  = sum_wd;
            res_status_in = ovf ? sca_pkg::ST_SAT : sca_pkg::ST_OK;
            state_in      = S_OUT;
         end
         // hand the result to the output register
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = res_found_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               rsp_done_in   = item_ff.end_of_element;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      q1_ff         <= q1_in;
      q2_ff         <= q2_in;
      q3_ff         <= q3_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      probe_ff      <= probe_in;
      mode_ff       <= mode_in;
      res_found_ff  <= res_found_in;
      res_slot_ff   <= res_slot_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_found_slot   = rsp_slot_ff;
   assign rsp_slot_value   = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_element_done = rsp_done_ff;

endmodule

// ===== src/sparse_csc_scatter_accumulate_core.sv =====
// sparse column scatter-accumulate core: from request accept to result valid, a load
// goes through dispatch and output; a read also fetches its slot sum; an accumulate
// reads the column bounds, sets the quartile points, probes the middle quartile,
// then an outer one and bisects as needed, one row-table probe per compare, then adds.
// one request is worked at a time; the next starts once the last result moves to the
// output register, which may stall; the queue takes up to 2 more meanwhile.
// after reset a clearing pass zeroes the 16384 slot sums, one per cycle, and no
// request is taken until it ends. depends on sca_pkg and submodules.
module sparse_csc_scatter_accumulate_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [14:0]        req_slot_address,
   input  logic [14:0]        req_load_word,
   input  logic signed [15:0] req_row_index,
   input  logic signed [15:0] req_column_index,
   input  logic signed [63:0] req_contribution,
   input  logic               req_end_of_element,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_found,
   output logic [13:0]        rsp_found_slot,
   output logic signed [63:0] rsp_slot_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_element_done
);

   sca_pkg::item_type q_wdata, q_rdata;
   logic              q_wr, q_rd, q_full, q_empty, clearing;

   sca_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_slot_address   (req_slot_address),
      .req_load_word      (req_load_word),
      .req_row_index      (req_row_index),
      .req_column_index   (req_column_index),
      .req_contribution   (req_contribution),
      .req_end_of_element (req_end_of_element),
      .clearing           (clearing),
      .q_full             (q_full),
      .q_wr               (q_wr),
      .q_wdata            (q_wdata)
   );

   sca_queue u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (q_wr),
      .wdata (q_wdata),
      .full  (q_full),
      .rd    (q_rd),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   sca_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_rdata          (q_rdata),
      .q_rd             (q_rd),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_found_slot   (rsp_found_slot),
      .rsp_slot_value   (rsp_slot_value),
      .rsp_status       (rsp_status),
      .rsp_element_done (rsp_element_done)
   );

   // no request enters while the sums are being cleared
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ready && q_empty)
      else $error("request taken during clearing pass");

   // a miss never carries a slot or a value
   a_miss_is_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_found_slot == '0 && rsp_slot_value == '0)
      else $error("miss result carries slot data");

   // found and status agree
   a_found_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_found == (rsp_status == sca_pkg::ST_OK ||
                                   rsp_status == sca_pkg::ST_SAT)))
      else $error("found flag disagrees with status");

endmodule

// ===== tb/sv/sca_checker.sv =====
`timescale 1ns / 1ps
// checker for the sparse column scatter-accumulate core: mirrors registers and tables,
// predicts every response and compares it field by field; depends on sca_pkg
module sca_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic               csr_pready,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [14:0]        req_slot_address,
   input  logic [14:0]        req_load_word,
   input  logic signed [15:0] req_row_index,
   input  logic signed [15:0] req_column_index,
   input  logic signed [63:0] req_contribution,
   input  logic               req_end_of_element,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_found,
   input  logic [13:0]        rsp_found_slot,
   input  logic signed [63:0] rsp_slot_value,
   input  logic [1:0]         rsp_status,
   input  logic               rsp_element_done,
   output int                 failures
);

   typedef struct {
      logic        found;
      logic [13:0] slot;
      logic [63:0] value;
      logic [1:0]  status;
      logic        done;
   } outcome_type;

   // mirrored registers and tables
   logic [10:0]        cols_in_use;
   logic signed [15:0] row_shift;
   logic signed [15:0] col_shift;
   logic [14:0]        col_start_tab [0:sca_pkg::MAX_COLS];
   logic [15:0]        row_tab [0:sca_pkg::MAX_NNZ-1];
   logic [63:0]        sum_tab [0:sca_pkg::MAX_NNZ-1];
   outcome_type        pending [$];

   initial begin
      failures = 0;
      foreach (sum_tab[k]) sum_tab[k] = '0;
   end

   // quartile split, then bisection over slots lo..hi
   function automatic int locate_slot(int lo, int hi, int row);
      int q1, q2, q3, quarter, r1, r2, r3, a, b, mid, rv;
      quarter = (hi - lo) / 4;
      q1 = lo + quarter;
      q2 = q1 + quarter;
      q3 = q2 + quarter;
      r1 = int'(row_tab[q1]);
      r2 = int'(row_tab[q2]);
      r3 = int'(row_tab[q3]);
      if (r2 < row) begin
         if (r3 < row) begin a = q3 + 1; b = hi; end
         else if (r3 > row) begin a = q2 + 1; b = q3 - 1; end
         else return q3;
      end else if (r2 > row) begin
         if (r1 < row) begin a = q1 + 1; b = q2 - 1; end
         else if (r1 > row) begin a = lo; b = q1 - 1; end
         else return q1;
      end else begin
         return q2;
      end
      while (a <= b) begin
         mid = a + (b - a) / 2;
         rv = int'(row_tab[mid]);
         if (rv < row) a = mid + 1;
         else if (rv > row) b = mid - 1;
         else return mid;
      end
      return -1;
   endfunction

   // works out the response of one request and updates the tables
   function automatic outcome_type scatter_predict(logic [1:0] op, logic [14:0] addr,
         logic [14:0] word, logic signed [15:0] ri, logic signed [15:0] ci,
         logic [63:0] cv, logic eoe);
      outcome_type o;
      int row, col, limit, lo, hi_end, k;
      logic [63:0] a, r;
      o = '{found: 1'b0, slot: '0, value: '0, status: sca_pkg::ST_OK, done: eoe};
      case (op)
         sca_pkg::OP_LOAD_COL: begin
            if (addr <= sca_pkg::MAX_COLS) begin
               col_start_tab[addr] = word;
               o.found = 1'b1; o.slot = addr[13:0];
            end else o.status = sca_pkg::ST_RANGE;
         end
         sca_pkg::OP_LOAD_ROW: begin
            if (addr < sca_pkg::MAX_NNZ) begin
               row_tab[addr] = {1'b0, word};
               sum_tab[addr] = '0;
               o.found = 1'b1; o.slot = addr[13:0];
            end else o.status = sca_pkg::ST_RANGE;
         end
         sca_pkg::OP_READ: begin
            if (addr < sca_pkg::MAX_NNZ) begin
               o.found = 1'b1; o.slot = addr[13:0]; o.value = sum_tab[addr];
            end else o.status = sca_pkg::ST_RANGE;
         end
         default: begin
            row = int'(ri) + int'(row_shift);
            col = int'(ci) + int'(col_shift);
            limit = (int'(cols_in_use) > sca_pkg::MAX_COLS) ? sca_pkg::MAX_COLS :
                    int'(cols_in_use);
            if (col < 0 || col >= limit) begin
               o.status = sca_pkg::ST_RANGE;
            end else begin
               lo = int'(col_start_tab[col]);
               hi_end = int'(col_start_tab[col + 1]);
               if (hi_end > sca_pkg::MAX_NNZ) hi_end = sca_pkg::MAX_NNZ;
               k = (lo < hi_end) ? locate_slot(lo, hi_end - 1, row) : -1;
               if (k < 0) begin
                  o.status = sca_pkg::ST_MISS;
               end else begin
                  a = sum_tab[k];
                  r = a + cv;
                  if (a[63] == cv[63] && r[63] != a[63]) begin
                     r = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                     o.status = sca_pkg::ST_SAT;
                  end
                  sum_tab[k] = r;
                  o.found = 1'b1; o.slot = k[13:0]; o.value = r;
               end
            end
         end
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cols_in_use <= 11'd1024;
         row_shift <= '0;
         col_shift <= '0;
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               sca_pkg::CSR_NUM_COLS:   cols_in_use <= csr_pwdata[10:0];
               sca_pkg::CSR_ROW_OFFSET: row_shift <= csr_pwdata[15:0];
               sca_pkg::CSR_COL_OFFSET: col_shift <= csr_pwdata[15:0];
               default: ;
            endcase
         end
         // accepted request
         if (req_valid && req_ready)
            pending.push_back(scatter_predict(req_operation, req_slot_address,
               req_load_word, req_row_index, req_column_index, req_contribution,
               req_end_of_element));
         // accepted response
         if (rsp_valid && rsp_ready) begin
            if (pending.size() == 0) begin
               failures++;
               if (failures <= 10) $display("unexpected response at %0t", $realtime);
            end else begin
               outcome_type e;
               e = pending.pop_front();
               if (e.found !== rsp_found || e.slot !== rsp_found_slot ||
                   e.value !== rsp_slot_value || e.status !== rsp_status ||
                   e.done !== rsp_element_done) begin
                  failures++;
                  if (failures <= 10)
                     $display({"mismatch at %0t: exp f=%0b s=%0d v=%h st=%0d d=%0b,",
                               " got f=%0b s=%0d v=%h st=%0d d=%0b"},
                        $realtime, e.found, e.slot, e.value, e.status, e.done, rsp_found,
                        rsp_found_slot, rsp_slot_value, rsp_status, rsp_element_done);
               end
            end
         end
      end
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// top of the testbench for the sparse column scatter-accumulate core: clock, reset,
// register phases and request stimulus; depends on sca_pkg, the core and sca_checker
module testbench;

   localparam int STALL_LIMIT = 100000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [3:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_operation = sca_pkg::OP_READ;
   logic [14:0]        req_slot_address = '0;
   logic [14:0]        req_load_word = '0;
   logic signed [15:0] req_row_index = '0;
   logic signed [15:0] req_column_index = '0;
   logic signed [63:0] req_contribution = '0;
   logic               req_end_of_element = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_found;
   logic [13:0]        rsp_found_slot;
   logic signed [63:0] rsp_slot_value;
   logic [1:0]         rsp_status;
   logic               rsp_element_done;
   int                 failures;

   // stimulus-side view of the tables, to keep searches on written entries
   logic [14:0]        start_shadow [0:sca_pkg::MAX_COLS];
   bit                 start_known [0:sca_pkg::MAX_COLS];
   logic [14:0]        row_shadow [0:sca_pkg::MAX_NNZ-1];
   bit                 row_known [0:sca_pkg::MAX_NNZ-1];
   logic [10:0]        cur_cols = 11'd1024;
   logic signed [15:0] cur_row_shift = '0;
   logic signed [15:0] cur_col_shift = '0;
   int                 sent = 0;
   int                 got = 0;
   int                 idle_cycles = 0;
   bit                 calm = 1'b0;

   sparse_csc_scatter_accumulate_core DUT (.*);

   sca_checker checker_i (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // response side back-pressure
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= calm || ($urandom_range(0, 99) >= 35);
   end

   // handshake counters and stall watchdog
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) got <= got + 1;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // one request, held until accepted, then maybe a gap
   task automatic send_req(input logic [1:0] op, input logic [14:0] addr,
         input logic [14:0] word, input logic signed [15:0] ri,
         input logic signed [15:0] ci, input logic [63:0] cv, input logic eoe);
      req_valid <= 1'b1; req_operation <= op; req_slot_address <= addr;
      req_load_word <= word; req_row_index <= ri; req_column_index <= ci;
      req_contribution <= cv; req_end_of_element <= eoe;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      if (op == sca_pkg::OP_LOAD_COL && addr <= sca_pkg::MAX_COLS) begin
         start_shadow[addr] = word; start_known[addr] = 1'b1;
      end
      if (op == sca_pkg::OP_LOAD_ROW && addr < sca_pkg::MAX_NNZ) begin
         row_shadow[addr] = word; row_known[addr] = 1'b1;
      end
      if (!calm && $urandom_range(0, 99) < 35) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // true when an accumulate cannot touch an unwritten table entry
   function automatic bit search_is_safe(logic signed [15:0] ci);
      int col, limit, lo, hi_end;
      col = int'(ci) + int'(cur_col_shift);
      limit = (int'(cur_cols) > sca_pkg::MAX_COLS) ? sca_pkg::MAX_COLS : int'(cur_cols);
      if (col < 0 || col >= limit) return 1'b1;
      if (!start_known[col] || !start_known[col + 1]) return 1'b0;
      lo = int'(start_shadow[col]);
      hi_end = int'(start_shadow[col + 1]);
      if (hi_end > sca_pkg::MAX_NNZ) hi_end = sca_pkg::MAX_NNZ;
      for (int k = lo; k < hi_end; k++)
         if (!row_known[k]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 5))
         0: return {$urandom, $urandom};
         1: return $urandom_range(0, 1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
         2: return {{32{1'b1}}, $urandom};
         default: return {{40{1'b0}}, 24'($urandom)} - 64'd8_000_000;
      endcase
   endfunction

   // accumulate aimed at slot k of column c, falling back to a rejected column
   task automatic aimed_accum(input int c, input int k, input bit has_slot);
      int ri, ci;
      logic signed [15:0] r16, c16;
      ri = has_slot ? int'(row_shadow[k]) - int'(cur_row_shift) : $urandom_range(0, 65535) - 32768;
      if ($urandom_range(0, 9) == 0) ri += $urandom_range(0, 1) ? 1 : -1;
      ci = c - int'(cur_col_shift);
      if (ri < -32768 || ri > 32767) ri = $urandom_range(0, 65535) - 32768;
      if (ci < -32768 || ci > 32767) ci = $urandom_range(0, 65535) - 32768;
      r16 = 16'(ri);
      c16 = 16'(ci);
      if (!search_is_safe(c16)) c16 = 16'sh8000;
      send_req(sca_pkg::OP_ACCUM, 15'($urandom), 15'($urandom), r16, c16, pick_value(),
         1'($urandom));
   endtask

   // lays out one column with rising rows, then works on it
   task automatic column_burst();
      int c, s, n, r;
      c = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 80) : $urandom_range(0, 8);
      s = ($urandom_range(0, 1) != 0) ? c * 16 : $urandom_range(0, sca_pkg::MAX_NNZ - n);
      r = $urandom_range(0, 2000);
      send_req(sca_pkg::OP_LOAD_COL, 15'(c), 15'(s), '0, '0, '0, 1'b0);
      send_req(sca_pkg::OP_LOAD_COL, 15'(c + 1), 15'(s + n), '0, '0, '0, 1'b0);
      for (int k = 0; k < n; k++) begin
         send_req(sca_pkg::OP_LOAD_ROW, 15'(s + k), 15'(r), '0, '0, '0, 1'b0);
         r += $urandom_range(1, 300);
         if (r > 32767) r = 32767;
      end
      repeat ($urandom_range(2, 2 * n + 3))
         aimed_accum(c, s + $urandom_range(0, (n > 0) ? n - 1 : 0), n > 0);
      if (n > 0)
         send_req(sca_pkg::OP_READ, 15'(s + $urandom_range(0, n - 1)), '0, '0, '0, '0,
            1'b0);
   endtask

   // unstructured request of any kind
   task automatic noise_req();
      logic [1:0] op;
      logic signed [15:0] ci;
      op = 2'($urandom);
      ci = 16'($urandom);
      if (op == sca_pkg::OP_ACCUM && !search_is_safe(ci)) ci = 16'sh8000;
      send_req(op, 15'($urandom), 15'($urandom), 16'($urandom), ci, pick_value(),
         1'($urandom));
   endtask

   task automatic set_registers(input logic [10:0] nc, input logic signed [15:0] ro,
         input logic signed [15:0] co);
      req_valid <= 1'b0;
      while (got != sent) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_write(sca_pkg::CSR_NUM_COLS, {21'd0, nc});
      csr_write(sca_pkg::CSR_ROW_OFFSET, {16'd0, ro});
      csr_write(sca_pkg::CSR_COL_OFFSET, {16'd0, co});
      cur_cols = nc; cur_row_shift = ro; cur_col_shift = co;
   endtask

   initial begin
      logic [10:0] nc;
      logic signed [15:0] ro, co;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: column 0 holds rows 5, 9, 32767; column 1 empty; last column clamped
      send_req(sca_pkg::OP_LOAD_COL, 15'd0, 15'd0, '0, '0, '0, 1'b0);
      send_req(sca_pkg::OP_LOAD_COL, 15'd1, 15'd3, '0, '0, '0, 1'b1);
      send_req(sca_pkg::OP_LOAD_COL, 15'd2, 15'd3, '0, '0, '0, 1'b0);
      send_req(sca_pkg::OP_LOAD_ROW, 15'd0, 15'd5, '0, '0, '0, 1'b0);
      send_req(sca_pkg::OP_LOAD_ROW, 15'd1, 15'd9, '0, '0, '0, 1'b0);
      send_req(sca_pkg::OP_LOAD_ROW, 15'd2, 15'd32767, '0, '0, '0, 1'b0);
      send_req(sca_pkg::OP_LOAD_COL, 15'd1023, 15'd16382, '0, '0, '0, 1'b0);
      send_req(sca_pkg::OP_LOAD_COL, 15'd1024, 15'd32767, '0, '0, '0, 1'b0);
      send_req(sca_pkg::OP_LOAD_ROW, 15'd16382, 15'd100, '0, '0, '0, 1'b0);
      send_req(sca_pkg::OP_LOAD_ROW, 15'd16383, 15'd200, '0, '0, '0, 1'b0);
      // out-of-range addresses
      send_req(sca_pkg::OP_LOAD_COL, 15'd1025, 15'd1, '0, '0, '0, 1'b1);
      send_req(sca_pkg::OP_LOAD_COL, 15'd32767, 15'd1, '0, '0, '0, 1'b0);
      send_req(sca_pkg::OP_LOAD_ROW, 15'd16384, 15'd1, '0, '0, '0, 1'b0);
      send_req(sca_pkg::OP_LOAD_ROW, 15'd32767, 15'd1, '0, '0, '0, 1'b0);
      send_req(sca_pkg::OP_READ, 15'd16384, '0, '0, '0, '0, 1'b1);
      // hits, misses, rejected columns and both saturation directions
      send_req(sca_pkg::OP_ACCUM, '0, '0, 16'sd9, 16'sd0, 64'd1, 1'b1);
      send_req(sca_pkg::OP_ACCUM, '0, '0, 16'sd32767, 16'sd0, 64'h7FFF_FFFF_FFFF_FFFF,
         1'b0);
      send_req(sca_pkg::OP_ACCUM, '0, '0, 16'sd32767, 16'sd0, 64'h7FFF_FFFF_FFFF_FFFF,
         1'b0);
      send_req(sca_pkg::OP_ACCUM, '0, '0, 16'sd5, 16'sd0, 64'h8000_0000_0000_0000, 1'b0);
      send_req(sca_pkg::OP_ACCUM, '0, '0, 16'sd5, 16'sd0, 64'h8000_0000_0000_0000, 1'b1);
      send_req(sca_pkg::OP_ACCUM, '0, '0, 16'sd7, 16'sd0, 64'd3, 1'b0);
      send_req(sca_pkg::OP_ACCUM, '0, '0, 16'sd5, 16'sd1, 64'd3, 1'b0);
      send_req(sca_pkg::OP_ACCUM, '0, '0, 16'sd5, -16'sd1, 64'd3, 1'b0);
      send_req(sca_pkg::OP_ACCUM, '0, '0, 16'sd200, 16'sd1023, 64'd7, 1'b1);
      send_req(sca_pkg::OP_READ, 15'd1, '0, '0, '0, '0, 1'b0);

      // random phases, each under its own register setting
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin nc = 11'd1024; ro = 16'sd0; co = 16'sd0; end
            1: begin nc = 11'd1; ro = 16'sh7FFF; co = 16'sh8000; end
            2: begin nc = 11'd2047; ro = 16'sh8000; co = 16'sh7FFF; end
            3: begin nc = 11'd0; ro = 16'($urandom); co = 16'($urandom); end
            4: begin nc = 11'($urandom_range(1, 1024)); ro = 16'($urandom); co = 16'sd5; end
            default: begin nc = 11'd1024; ro = 16'($urandom_range(0, 40)) - 16'sd20;
               co = 16'sd0; end
         endcase
         set_registers(nc, ro, co);
         while (sent < 60 + (p + 1) * 160) begin
            calm = (sent > 400 && sent < 560);
            if ($urandom_range(0, 3) != 0) column_burst();
            else noise_req();
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (got != sent) @(posedge clock);
      repeat (60) @(posedge clock);
      if (failures == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
src/sca_pkg.sv
src/sca_front.sv
src/sca_queue.sv
src/sca_back.sv
src/sparse_csc_scatter_accumulate_core.sv
tb/sv/sca_checker.sv
tb/sv/testbench.sv
